// ----- rtl/tcce_pkg.sv -----
package tcce_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0]  RESET_ATTR  = 8'h0F;
    localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

    // Side effects of one put on the screen store.
    typedef struct packed {
        logic wr;       // a cell is written at the write column
        logic blank;    // the written cell is a blank rather than the byte
        logic scroll;   // the cursor ran past the last row
    } t_step_ctl;

endpackage

// ----- rtl/tcce_ram.sv -----
module tcce_ram #(
    parameter int DEPTH = tcce_pkg::DEF_ROWS * tcce_pkg::DEF_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcce_cursor.sv -----
module tcce_cursor #(
    parameter int ROWS  = tcce_pkg::DEF_ROWS,
    parameter int COLS  = tcce_pkg::DEF_COLS,
    parameter int ROW_W = $clog2(ROWS),
    parameter int COL_W = $clog2(COLS)
) (
    input  logic [ROW_W-1:0]    i_row,
    input  logic [COL_W-1:0]    i_col,
    input  logic [7:0]          i_char,
    output logic [ROW_W-1:0]    o_row,
    output logic [COL_W-1:0]    o_col,
    output logic [COL_W-1:0]    o_wr_col,
    output tcce_pkg::t_step_ctl o_ctl
);

    localparam logic [COL_W:0]   COLS_L    = (COL_W+1)'(COLS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   TAB_MASK  = {{(COL_W-2){1'b1}}, 3'b000};

    logic [COL_W:0] col_ext;
    logic [COL_W:0] col_inc;
    logic [COL_W:0] col_tab;
    logic           adv;

    always_comb begin
        col_ext  = {1'b0, i_col};
        col_inc  = col_ext + (COL_W+1)'(1);
        col_tab  = (col_ext + (COL_W+1)'(8)) & TAB_MASK;
        adv      = 1'b0;
        o_col    = i_col;
        o_wr_col = i_col;
        o_ctl    = '0;

        case (i_char)
            tcce_pkg::CH_LF: begin
                o_col = '0;
                adv   = 1'b1;
            end
            tcce_pkg::CH_CR: begin
                o_col = '0;
            end
            tcce_pkg::CH_TAB: begin
                if (col_tab >= COLS_L) begin
                    o_col = '0;
                    adv   = 1'b1;
                end else begin
                    o_col = col_tab[COL_W-1:0];
                end
            end
            tcce_pkg::CH_BS: begin
                // Backspace stays on its row and blanks the cell it lands on.
                if (i_col != '0) begin
                    o_col = i_col - COL_W'(1);
                end
                o_wr_col    = o_col;
                o_ctl.wr    = 1'b1;
                o_ctl.blank = 1'b1;
            end
            default: begin
                o_ctl.wr = 1'b1;
                if (col_inc >= COLS_L) begin
                    o_col = '0;
                    adv   = 1'b1;
                end else begin
                    o_col = col_inc[COL_W-1:0];
                end
            end
        endcase

        o_row = i_row;
        if (adv) begin
            if (i_row == LAST_ROW) begin
                o_ctl.scroll = 1'b1;
            end else begin
                o_row = i_row + ROW_W'(1);
            end
        end
    end

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// Teletype-style text console with a cursor and a ROWS x COLS screen store.
// A command is transferred on a rising edge with start high and busy low; i_kind
// selects put character, read cell, clear screen or none. Every command yields one
// result, shown for a single cycle with o_done high, in the cycle after the
// command finishes. The receiver cannot stall; results are never held back.
// How each command runs, set by the single write port of the screen memory:
//   put without scroll: the cell write happens on the transfer edge,
//   read: passes through a read state for the synchronous memory read,
//   put that scrolls: the freed row is blanked one cell a cycle,
//   clear: every cell is blanked one a cycle.
// Scrolling moves a top-row pointer instead of copying rows.
// After reset busy stays high while the memory is swept to spaces in
// attribute 0x0F; attribute writes are taken throughout.
// The attribute register is written on any edge with i_cfg_we high and
// applies to cells written after that edge, also by a clear or scroll under way.
module text_console_cursor_engine #(
    parameter int ROWS = tcce_pkg::DEF_ROWS,
    parameter int COLS = tcce_pkg::DEF_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_done,
    output logic [4:0] o_cur_row_out,
    output logic [6:0] o_cur_col_out,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    output logic       o_scrolled
);

    localparam int NCELLS = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(NCELLS);

    localparam logic [ROW_W:0]    ROWS_L    = (ROW_W+1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COL  = ADDR_W'(COLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [7:0]        r_attr;
    logic              r_rd_ok, n_rd_ok;

    logic              r_done, n_done;
    logic [ROW_W-1:0]  r_o_row, n_o_row;
    logic [COL_W-1:0]  r_o_col, n_o_col;
    logic [7:0]        r_o_char, n_o_char;
    logic [7:0]        r_o_attr, n_o_attr;
    logic              r_o_scr, n_o_scr;

    logic                accept;
    logic [ROW_W-1:0]    put_row;
    logic [COL_W-1:0]    put_col;
    logic [COL_W-1:0]    wr_col;
    tcce_pkg::t_step_ctl put_ctl;

    logic [ROW_W:0]    wr_sum;
    logic [ROW_W-1:0]  wr_phys;
    logic [ADDR_W-1:0] wr_addr;
    logic [ROW_W:0]    rd_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [15:0]       mem_rdata;
    logic [15:0]       blank;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign blank  = {r_attr, tcce_pkg::CH_SPACE};

    tcce_cursor #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_cursor (
        .i_row    (r_row),
        .i_col    (r_col),
        .i_char   (i_char_code),
        .o_row    (put_row),
        .o_col    (put_col),
        .o_wr_col (wr_col),
        .o_ctl    (put_ctl)
    );

    // Logical rows map onto physical rows through the top-row pointer.
    always_comb begin
        wr_sum = {1'b0, r_row} + {1'b0, r_top};
        if (wr_sum >= ROWS_L) begin
            wr_sum = wr_sum - ROWS_L;
        end
        wr_phys = wr_sum[ROW_W-1:0];
        wr_addr = ADDR_W'(wr_phys) * COLS_A + ADDR_W'(wr_col);

        rd_in_range = ({2'b00, i_read_row} < 7'(ROWS)) && ({2'b00, i_read_col} < 9'(COLS));
        rd_sum = {1'b0, ROW_W'(i_read_row)} + {1'b0, r_top};
        if (rd_sum >= ROWS_L) begin
            rd_sum = rd_sum - ROWS_L;
        end
        rd_phys = rd_sum[ROW_W-1:0];
        rd_addr = ADDR_W'(rd_phys) * COLS_A + ADDR_W'(COL_W'(i_read_col));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr;
        mem_wdata = blank;
        mem_re    = 1'b0;
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = tcce_pkg::RESET_BLANK;
            end
            ST_IDLE: begin
                mem_we    = accept && (i_kind == tcce_pkg::KIND_PUT) && put_ctl.wr;
                mem_wdata = put_ctl.blank ? blank : {r_attr, i_char_code};
                mem_re    = accept && (i_kind == tcce_pkg::KIND_READ) && rd_in_range;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_waddr = r_base + r_cnt;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tcce_ram #(
        .DEPTH (NCELLS),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_top    = r_top;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_rd_ok  = r_rd_ok;
        n_done   = 1'b0;
        n_o_row  = r_o_row;
        n_o_col  = r_o_col;
        n_o_char = r_o_char;
        n_o_attr = r_o_attr;
        n_o_scr  = r_o_scr;

        case (r_state)
            ST_INIT: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_o_row  = r_row;
                    n_o_col  = r_col;
                    n_o_char = '0;
                    n_o_attr = '0;
                    n_o_scr  = 1'b0;
                    case (i_kind)
                        tcce_pkg::KIND_PUT: begin
                            n_row   = put_row;
                            n_col   = put_col;
                            n_o_row = put_row;
                            n_o_col = put_col;
                            if (put_ctl.scroll) begin
                                // The old top row becomes the new bottom row.
                                n_base  = ADDR_W'(r_top) * COLS_A;
                                n_top   = (r_top == LAST_ROW) ? '0 : r_top + ROW_W'(1);
                                n_cnt   = '0;
                                n_state = ST_SCROLL;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        tcce_pkg::KIND_READ: begin
                            n_rd_ok = rd_in_range;
                            n_state = ST_READ;
                        end
                        tcce_pkg::KIND_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_top   = '0;
                            n_o_row = '0;
                            n_o_col = '0;
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_o_char = r_rd_ok ? mem_rdata[7:0] : 8'h00;
                n_o_attr = r_rd_ok ? mem_rdata[15:8] : 8'h00;
                n_done   = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_CLEAR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_COL) begin
                    n_cnt   = '0;
                    n_o_scr = 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_attr  <= tcce_pkg::RESET_ATTR;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_rd_ok  <= n_rd_ok;
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_char <= n_o_char;
        r_o_attr <= n_o_attr;
        r_o_scr  <= n_o_scr;
    end

    assign o_done        = r_done;
    assign o_cur_row_out = 5'(r_o_row);
    assign o_cur_col_out = 7'(r_o_col);
    assign o_cell_char   = r_o_char;
    assign o_cell_attr   = r_o_attr;
    assign o_scrolled    = r_o_scr;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(accept) || ($past(r_state) != ST_IDLE && $past(r_state) != ST_INIT)))
        else $error("result strobe without a command in progress");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && ({1'b0, r_col} < (COL_W+1)'(COLS)) && (r_top <= LAST_ROW))
        else $error("cursor or top-row pointer out of range");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_o_scr) |-> (r_o_row == LAST_ROW))
        else $error("scroll reported with cursor off the last row");

    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && mem_we) |-> (accept && i_kind == tcce_pkg::KIND_PUT))
        else $error("screen write while idle without a put");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && $past(r_state) == ST_READ) |-> (r_state == ST_IDLE))
        else $error("read result while still busy");

endmodule

// ----- dv/text_console_cursor_engine_checker.sv -----
`timescale 1ns / 1ps

module text_console_cursor_engine_checker #(
    parameter int ROWS = tcce_pkg::DEF_ROWS,
    parameter int COLS = tcce_pkg::DEF_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_done,
    input  logic [4:0] i_cur_row_out,
    input  logic [6:0] i_cur_col_out,
    input  logic [7:0] i_cell_char,
    input  logic [7:0] i_cell_attr,
    input  logic       i_scrolled,
    output int         o_fail_count,
    output int         o_outstanding
);

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       scrolled;
    } t_cursor_report;

    logic [15:0]    screen_mirror [ROWS*COLS];
    int unsigned    model_row;
    int unsigned    model_col;
    logic [7:0]     attr_shadow;
    t_cursor_report expected_reports [$];
    int             fail_total = 0;
    int             pending    = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = pending;

    function automatic logic [15:0] blank_word();
        return {attr_shadow, tcce_pkg::CH_SPACE};
    endfunction

    task automatic fill_blank();
        for (int i = 0; i < ROWS*COLS; i++) begin
            screen_mirror[i] = blank_word();
        end
    endtask

    task automatic store_at_cursor(input logic [15:0] word);
        int unsigned idx;
        idx = model_row * COLS + model_col;
        if (idx < ROWS*COLS) begin
            screen_mirror[idx] = word;
        end
    endtask

    task automatic next_row();
        model_col = 0;
        model_row++;
    endtask

    task automatic predict_command(input logic [1:0] kind, input logic [7:0] ch,
                                   input logic [4:0] rr, input logic [6:0] rc,
                                   output t_cursor_report rep);
        logic [15:0] word;
        rep = '0;
        case (kind)
            tcce_pkg::KIND_PUT: begin
                case (ch)
                    tcce_pkg::CH_LF: next_row();
                    tcce_pkg::CH_CR: model_col = 0;
                    tcce_pkg::CH_TAB: begin
                        model_col = (model_col + 8) & ~32'd7;
                        if (model_col >= COLS) next_row();
                    end
                    tcce_pkg::CH_BS: begin
                        // Backspace stops at column 0 and never climbs a row.
                        if (model_col > 0) model_col--;
                        store_at_cursor(blank_word());
                    end
                    default: begin
                        store_at_cursor({attr_shadow, ch});
                        model_col++;
                        if (model_col >= COLS) next_row();
                    end
                endcase
                if (model_row >= ROWS) begin
                    for (int i = 0; i < (ROWS-1)*COLS; i++) begin
                        screen_mirror[i] = screen_mirror[i+COLS];
                    end
                    for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) begin
                        screen_mirror[i] = blank_word();
                    end
                    model_row    = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            tcce_pkg::KIND_READ: begin
                if (rr < ROWS && rc < COLS) begin
                    word     = screen_mirror[rr*COLS + rc];
                    rep.ch   = word[7:0];
                    rep.attr = word[15:8];
                end
            end
            tcce_pkg::KIND_CLEAR: begin
                fill_blank();
                model_row = 0;
                model_col = 0;
            end
            default: ;
        endcase
        rep.row = model_row[4:0];
        rep.col = model_col[6:0];
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Inputs change on the falling edge, so everything read here is the
    // value that the block itself sees on this rising edge.
    always @(posedge i_clk) begin
        t_cursor_report want;
        t_cursor_report rep;
        if (!i_rst_n) begin
            attr_shadow = tcce_pkg::RESET_ATTR;
            model_row   = 0;
            model_col   = 0;
            fill_blank();
            expected_reports.delete();
        end else begin
            if (i_cfg_we) attr_shadow = i_cfg_wdata;
            if (i_done) begin
                if (expected_reports.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cur_row_out", 32'(want.row), 32'(i_cur_row_out));
                    check_field("cur_col_out", 32'(want.col), 32'(i_cur_col_out));
                    check_field("cell_char", 32'(want.ch), 32'(i_cell_char));
                    check_field("cell_attr", 32'(want.attr), 32'(i_cell_attr));
                    check_field("scrolled", 32'(want.scrolled), 32'(i_scrolled));
                end
            end
            if (i_start && !i_busy) begin
                predict_command(i_kind, i_char_code, i_read_row, i_read_col, rep);
                expected_reports.push_back(rep);
            end
        end
        pending = expected_reports.size();
    end

endmodule

// ----- dv/text_console_cursor_engine_tb.sv -----
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;

    localparam int ROWS        = tcce_pkg::DEF_ROWS;
    localparam int COLS        = tcce_pkg::DEF_COLS;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;
    localparam int CYCLE_LIMIT = 10_000_000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic [1:0] i_kind      = tcce_pkg::KIND_NONE;
    logic [7:0] i_char_code = 8'd0;
    logic [4:0] i_read_row  = 5'd0;
    logic [6:0] i_read_col  = 7'd0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       o_done;
    logic [4:0] o_cur_row_out;
    logic [6:0] o_cur_col_out;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_attr;
    logic       o_scrolled;
    int         fail_count;
    int         outstanding;
    int         cycle_count = 0;

    always #1 i_clk = ~i_clk;

    text_console_cursor_engine #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_cur_row_out(o_cur_row_out),
        .o_cur_col_out(o_cur_col_out),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

    text_console_cursor_engine_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_cur_row_out(o_cur_row_out),
        .i_cur_col_out(o_cur_col_out),
        .i_cell_char  (o_cell_char),
        .i_cell_attr  (o_cell_attr),
        .i_scrolled   (o_scrolled),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Holds start high until the command is transferred.
    task automatic issue(input logic [1:0] kind, input logic [7:0] ch,
                         input logic [4:0] rr, input logic [6:0] rc);
        @(negedge i_clk);
        start       <= 1'b1;
        i_kind      <= kind;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do @(posedge i_clk); while (busy);
    endtask

    // Idle cycles carry junk on the command fields.
    task automatic idle_for(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start       <= 1'b0;
            i_kind      <= 2'($urandom);
            i_char_code <= 8'($urandom);
            i_read_row  <= 5'($urandom);
            i_read_col  <= 7'($urandom);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_attr(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'($urandom);
    endtask

    // Mostly puts, so the screen fills, wraps and scrolls; reads sample it.
    task automatic random_command();
        int unsigned r;
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [4:0]  rr;
        logic [6:0]  rc;
        r    = $urandom_range(0, 99);
        kind = tcce_pkg::KIND_PUT;
        ch   = 8'($urandom);
        rr   = 5'($urandom);
        rc   = 7'($urandom);
        if (r < 40) begin
            ch = 8'($urandom_range(0, 255));
        end else if (r < 52) begin
            ch = tcce_pkg::CH_LF;
        end else if (r < 57) begin
            ch = tcce_pkg::CH_CR;
        end else if (r < 63) begin
            ch = tcce_pkg::CH_TAB;
        end else if (r < 69) begin
            ch = tcce_pkg::CH_BS;
        end else if (r < 92) begin
            kind = tcce_pkg::KIND_READ;
            if ($urandom_range(0, 99) < 85) begin
                rr = 5'($urandom_range(0, ROWS - 1));
                rc = 7'($urandom_range(0, COLS - 1));
            end
        end else if (r < 97) begin
            kind = tcce_pkg::KIND_NONE;
        end else begin
            kind = tcce_pkg::KIND_CLEAR;
        end
        issue(kind, ch, rr, rc);
    endtask

    initial begin
        logic [7:0] phase_attr;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset contents, the corner cell and reads off the screen.
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_READ, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1));
        issue(tcce_pkg::KIND_READ, 8'h00, 5'(ROWS), 7'd0);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'(COLS));
        issue(tcce_pkg::KIND_READ, 8'h00, 5'h1F, 7'h7F);
        issue(tcce_pkg::KIND_NONE, 8'hFF, 5'h1F, 7'h7F);
        // Byte extremes, including those with the top bit set.
        issue(tcce_pkg::KIND_PUT, 8'h41, 5'h1F, 7'h7F);
        issue(tcce_pkg::KIND_PUT, 8'hFF, 5'd0, 7'd0);
        idle_for(pick_gap());
        issue(tcce_pkg::KIND_PUT, 8'h80, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_PUT, 8'h00, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'd1);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'd2);
        idle_for(pick_gap());
        issue(tcce_pkg::KIND_PUT, tcce_pkg::CH_TAB, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_PUT, tcce_pkg::CH_BS, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_PUT, tcce_pkg::CH_CR, 5'd0, 7'd0);
        // Backspace in column 0 stays put and blanks the cell.
        issue(tcce_pkg::KIND_PUT, tcce_pkg::CH_BS, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_PUT, tcce_pkg::CH_LF, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_PUT, 8'h7E, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        issue(tcce_pkg::KIND_READ, 8'h00, 5'd1, 7'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       phase_attr = 8'h00;
                1:       phase_attr = 8'hFF;
                default: phase_attr = 8'($urandom_range(0, 255));
            endcase
            write_attr(phase_attr);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_command();
                // One phase runs back to back with no idle cycles at all.
                if (p != 3) idle_for(pick_gap());
            end
        end

        wait_idle();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_cursor.sv
rtl/text_console_cursor_engine.sv
dv/text_console_cursor_engine_checker.sv
dv/text_console_cursor_engine_tb.sv
